FILE: rtl/psch_pkg.sv
// Shared types, codes and helpers for the process table scheduler.
// No dependencies; all rtl files but psch_ram import this package.
`default_nettype none

package psch_pkg;

  // request opcodes
  localparam logic [3:0] OP_TICK   = 4'd0;
  localparam logic [3:0] OP_CREATE = 4'd1;
  localparam logic [3:0] OP_YIELD  = 4'd2;
  localparam logic [3:0] OP_SLEEP  = 4'd3;
  localparam logic [3:0] OP_WAKE   = 4'd4;
  localparam logic [3:0] OP_PICK   = 4'd5;
  localparam logic [3:0] OP_SETPRI = 4'd6;
  localparam logic [3:0] OP_FREE   = 4'd7;
  localparam logic [3:0] OP_STATS  = 4'd8;

  // response status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_PRIO = 2'd1;
  localparam logic [1:0] STAT_NO_RUN   = 2'd2;

  // slot states
  localparam logic [1:0] SS_UNUSED   = 2'd0;
  localparam logic [1:0] SS_SLEEPING = 2'd1;
  localparam logic [1:0] SS_RUNNABLE = 2'd2;
  localparam logic [1:0] SS_RUNNING  = 2'd3;

  // pick policies; any other code behaves as round robin
  localparam logic [1:0] POL_RR  = 2'd0;
  localparam logic [1:0] POL_ACC = 2'd1;
  localparam logic [1:0] POL_VRT = 2'd2;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_STEP   = 1'b1;

  localparam logic [6:0] DECAY_RESET    = 7'd100;
  localparam logic [7:0] ACC_STEP_RESET = 8'd5;
  localparam logic [1:0] LVL_BAD        = 2'd3;

  typedef struct packed {
    logic [1:0]  state;
    logic [6:0]  decay;
    logic [31:0] acc;
    logic [31:0] run;
    logic [31:0] slp;
    logic [31:0] rdy;
    logic [31:0] last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  localparam rec_t REC_RESET = '{state: SS_UNUSED, decay: DECAY_RESET, acc: 32'd0,
                                 run: 32'd0, slp: 32'd0, rdy: 32'd0, last: 32'd0};

  typedef struct packed {
    logic       done;
    logic [6:0] quo;
  } vrt_res_t;

  // 75 + 25 * level; level 3 gives 125 as level 2 does
  function automatic logic [6:0] decay_of(input logic [1:0] lvl);
    logic [6:0] d;
    case (lvl)
      2'd0:    d = 7'd75;
      2'd1:    d = 7'd100;
      default: d = 7'd125;
    endcase
    return d;
  endfunction

  // (decay - 75) / 25, clipped to 0..2
  function automatic logic [1:0] prio_of(input logic [6:0] d);
    logic [1:0] p;
    if (d < 7'd100)      p = 2'd0;
    else if (d < 7'd125) p = 2'd1;
    else                 p = 2'd2;
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psch_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module psch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/psch_vrt.sv
// Virtual runtime unit: decay*run/(run+sleep+ready), 0 for a zero total.
// A multiply on start, then seven restoring divide steps. Uses psch_pkg.
`default_nettype none

module psch_vrt (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [6:0]          decay,
  input  wire logic [31:0]         run,
  input  wire logic [31:0]         slp,
  input  wire logic [31:0]         rdy,
  output psch_pkg::vrt_res_t       res
);
  import psch_pkg::*;

  logic        busy;
  logic        done;
  logic [2:0]  k;
  logic [39:0] rem;
  logic [39:0] dv;
  logic [6:0]  quo;
  logic        zero;
  logic [33:0] tot;

  assign tot = 34'(run) + 34'(slp) + 34'(rdy);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= 3'd6;
      end else if (busy) begin
        if (k == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 3'd1;
        end
      end
    end
  end

  // quotient never exceeds decay, so seven bits suffice
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 40'(decay) * 40'(run);
      dv   <= {tot, 6'd0};
      zero <= (tot == 34'd0);
      quo  <= 7'd0;
    end else if (busy) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        quo <= {quo[5:0], 1'b1};
      end else begin
        quo <= {quo[5:0], 1'b0};
      end
      dv <= dv >> 1;
    end
  end

  assign res.done = done;
  assign res.quo  = zero ? 7'd0 : quo;

endmodule

`default_nettype wire

FILE: rtl/process_table_scheduler.sv
// Create, wake and pick scan the slot table; a pick by least virtual runtime runs
// the divide unit on each runnable slot that it scans.
// One request at a time: the slot table RAM and its single read port set the scan.
// Reset clears control state and sweeps the table to its reset values, with no
// request taken meanwhile; configuration writes go on.
`default_nettype none

module process_table_scheduler #(
  parameter int SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  slot,
  input  wire logic [1:0]  priority_level,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [1:0]       status,
  output logic [5:0]       chosen_slot,
  output logic [1:0]       stat_priority,
  output logic [31:0]      stat_run_time,
  output logic [31:0]      stat_sleep_time,
  output logic [31:0]      stat_ready_time
);
  import psch_pkg::*;

  localparam int SW = $clog2(SLOTS);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_GET      = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_EV  = 4'd5;
  localparam logic [3:0] S_SCAN_DIV = 4'd6;
  localparam logic [3:0] S_WRITE    = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0]    state;
  logic [3:0]    op_q;
  logic [1:0]    lvl_q;
  logic [SW-1:0] ix;
  logic [SW-1:0] tgt;
  logic [SW-1:0] clr;
  logic [31:0]   now_time;
  logic [SW-1:0] rr_ptr;
  logic [1:0]    policy;
  logic [7:0]    acc_step;

  logic [SW-1:0] scan_addr;
  logic [SW-1:0] scan_cnt;
  logic          found;
  logic [SW-1:0] best_ix;
  logic [31:0]   best_key;

  rec_t          cur;
  rec_t          rdata;
  rec_t          nr;
  rec_t          acct;
  logic [REC_W-1:0] ram_rdata;
  logic [REC_W-1:0] ram_wdata;
  logic          we;
  logic [SW-1:0] waddr;
  logic [SW-1:0] raddr;

  logic [1:0]    res_status;
  logic [5:0]    res_chosen;
  logic [1:0]    res_prio;
  logic [31:0]   res_run;
  logic [31:0]   res_slp;
  logic [31:0]   res_rdy;

  vrt_res_t      vres;
  logic          vstart;

  logic          accept;
  logic          ok_slot;
  logic          is_pick;
  logic          rr_mode;
  logic          elig;
  logic          use_div;
  logic          eval_now;
  logic [31:0]   key_now;
  logic          take;
  logic          scan_last;
  logic          stop;
  logic          found_n;
  logic [SW-1:0] best_n;
  logic [SW-1:0] addr_next;
  logic [31:0]   least;
  logic [31:0]   dt;
  logic [32:0]   acc_sum;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign ok_slot   = 32'(slot) < 32'(SLOTS);

  assign rdata     = rec_t'(ram_rdata);
  assign ram_wdata = (state == S_CLEAR) ? REC_RESET : nr;
  assign we        = (state == S_CLEAR) || (state == S_WRITE);
  assign waddr     = (state == S_CLEAR) ? clr : tgt;
  assign raddr     = (state == S_RD) ? tgt : scan_addr;

  psch_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  psch_vrt u_vrt (
    .clk   (clk),
    .rst   (rst),
    .start (vstart),
    .decay (rdata.decay),
    .run   (rdata.run),
    .slp   (rdata.slp),
    .rdy   (rdata.rdy),
    .res   (vres)
  );

  // scan evaluation
  assign is_pick   = (op_q == OP_PICK);
  assign rr_mode   = is_pick && !(policy == POL_ACC || policy == POL_VRT);
  assign elig      = is_pick ? (rdata.state == SS_RUNNABLE)
                             : ((rdata.state == SS_RUNNABLE || rdata.state == SS_RUNNING)
                                && scan_addr != ix);
  assign use_div   = is_pick && (policy == POL_VRT) && elig;
  assign vstart    = (state == S_SCAN_EV) && use_div;
  assign eval_now  = ((state == S_SCAN_EV) && !use_div) || ((state == S_SCAN_DIV) && vres.done);
  assign key_now   = (state == S_SCAN_DIV) ? 32'(vres.quo) : rdata.acc;
  assign take      = eval_now && elig && (rr_mode || !found || key_now < best_key);
  assign scan_last = (scan_cnt == SW'(SLOTS - 1));
  assign stop      = eval_now && (scan_last || (rr_mode && elig));
  assign found_n   = found || take;
  assign best_n    = take ? scan_addr : best_ix;
  assign addr_next = (scan_addr == SW'(SLOTS - 1)) ? '0 : scan_addr + SW'(1);
  assign least     = found ? best_key : 32'd0;

  // new record for the target slot
  assign dt      = now_time - cur.last;
  assign acc_sum = 33'(cur.acc) + 33'(acc_step);

  always_comb begin
    acct      = cur;
    acct.last = now_time;
    case (cur.state)
      SS_RUNNABLE: acct.rdy = cur.rdy + dt;
      SS_RUNNING:  acct.run = cur.run + dt;
      SS_SLEEPING: acct.slp = cur.slp + dt;
      default:     acct.last = now_time;
    endcase
    nr = cur;
    case (op_q)
      OP_CREATE: begin
        nr = '{state: SS_RUNNABLE, decay: decay_of(lvl_q), acc: least,
               run: 32'd0, slp: 32'd0, rdy: 32'd0, last: now_time};
      end
      OP_YIELD: begin
        nr       = acct;
        nr.state = SS_RUNNABLE;
        nr.acc   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      end
      OP_SLEEP: begin
        nr       = acct;
        nr.state = SS_SLEEPING;
      end
      OP_WAKE: begin
        nr       = acct;
        nr.state = SS_RUNNABLE;
        nr.acc   = least;
      end
      OP_PICK: begin
        nr       = acct;
        nr.state = SS_RUNNING;
      end
      OP_FREE: begin
        nr       = acct;
        nr.state = SS_UNUSED;
      end
      OP_SETPRI: nr.decay = decay_of(lvl_q);
      default:   nr = cur;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= POL_RR;
      acc_step <= ACC_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: policy   <= cfg_data[1:0];
        CFG_STEP:   acc_step <= cfg_data;
        default:    policy   <= policy;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      now_time <= 32'd0;
      rr_ptr   <= '0;
      found    <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + SW'(1);
          if (clr == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q       <= opcode;
            lvl_q      <= priority_level;
            ix         <= SW'(slot);
            tgt        <= SW'(slot);
            res_status <= STAT_OK;
            res_chosen <= 6'd0;
            res_prio   <= 2'd0;
            res_run    <= 32'd0;
            res_slp    <= 32'd0;
            res_rdy    <= 32'd0;
            found      <= 1'b0;
            scan_cnt   <= '0;
            scan_addr  <= '0;
            state      <= S_FINISH;
            if (opcode == OP_TICK) begin
              now_time <= now_time + 32'd1;
            end else if ((opcode == OP_CREATE || opcode == OP_SETPRI)
                         && priority_level == LVL_BAD) begin
              res_status <= STAT_BAD_PRIO;
            end else if (opcode == OP_PICK) begin
              scan_addr <= (policy == POL_ACC || policy == POL_VRT) ? '0 : rr_ptr;
              state     <= S_SCAN_RD;
            end else if (ok_slot) begin
              if (opcode == OP_CREATE) begin
                state <= S_SCAN_RD;
              end else if (opcode inside {OP_YIELD, OP_SLEEP, OP_WAKE, OP_SETPRI,
                                          OP_FREE, OP_STATS}) begin
                state <= S_RD;
              end
            end
          end
        end
        S_RD: state <= S_GET;
        S_GET: begin
          cur   <= rdata;
          state <= S_FINISH;
          case (op_q)
            OP_YIELD, OP_SLEEP: if (rdata.state == SS_RUNNING) state <= S_WRITE;
            OP_WAKE:            if (rdata.state == SS_SLEEPING) state <= S_SCAN_RD;
            OP_SETPRI, OP_FREE, OP_PICK: state <= S_WRITE;
            OP_STATS: begin
              res_prio <= prio_of(rdata.decay);
              res_run  <= rdata.run;
              res_slp  <= rdata.slp;
              res_rdy  <= rdata.rdy;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV, S_SCAN_DIV: begin
          if (vstart) begin
            state <= S_SCAN_DIV;
          end else if (eval_now) begin
            found <= found_n;
            if (take) begin
              best_ix  <= scan_addr;
              best_key <= key_now;
              if (rr_mode) begin
                rr_ptr <= addr_next;
              end
            end
            if (stop) begin
              if (!is_pick) begin
                state <= S_WRITE;
              end else if (found_n) begin
                tgt   <= best_n;
                state <= S_RD;
              end else begin
                res_status <= STAT_NO_RUN;
                state      <= S_FINISH;
              end
            end else begin
              scan_addr <= addr_next;
              scan_cnt  <= scan_cnt + SW'(1);
              state     <= S_SCAN_RD;
            end
          end
        end
        S_WRITE: begin
          if (is_pick) begin
            res_chosen <= 6'(tgt);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp_valid || rsp_ready)) begin
      status          <= res_status;
      chosen_slot     <= res_chosen;
      stat_priority   <= res_prio;
      stat_run_time   <= res_run;
      stat_sleep_time <= res_slp;
      stat_ready_time <= res_rdy;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> state == S_CLEAR)
    else $error("table sweep not started after reset");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("table written while idle");
  a_div_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    vres.done |-> state == S_SCAN_DIV)
    else $error("divide result outside scan");
  a_no_run_only_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_status == STAT_NO_RUN) |-> op_q == OP_PICK)
    else $error("no-runnable status on a non-pick request");
  a_pick_writes_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && op_q == OP_PICK) |-> nr.state == SS_RUNNING)
    else $error("picked slot not made running");

endmodule

`default_nettype wire

FILE: tb/sv/psch_checker.sv
// Checker for the process table scheduler: watches the request and response
// channels, predicts each response from its own copy of the slot table.
// Depends on psch_pkg for opcodes, status codes, slot states and policies.
`timescale 1ns / 1ps

module psch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [3:0]  opcode,
  input  logic [5:0]  slot,
  input  logic [1:0]  priority_level,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [1:0]  status,
  input  logic [5:0]  chosen_slot,
  input  logic [1:0]  stat_priority,
  input  logic [31:0] stat_run_time,
  input  logic [31:0] stat_sleep_time,
  input  logic [31:0] stat_ready_time,
  output int          fail_count,
  output int          pending
);
  import psch_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  chosen;
    logic [1:0]  prio;
    logic [31:0] run;
    logic [31:0] slp;
    logic [31:0] rdy;
  } sched_rsp_t;

  logic [1:0]  st [64];
  logic [6:0]  decay [64];
  logic [31:0] acc [64];
  logic [31:0] run_t [64];
  logic [31:0] slp_t [64];
  logic [31:0] rdy_t [64];
  logic [31:0] last_t [64];
  logic [31:0] now_t;
  logic [5:0]  rr_ptr;
  logic [1:0]  pol;
  logic [7:0]  acc_step;

  sched_rsp_t expected_rsps[$];

  assign pending = expected_rsps.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // fold elapsed time into the bucket of the state being left
  function automatic void settle(input int s);
    logic [31:0] dt;
    dt = now_t - last_t[s];
    case (st[s])
      SS_RUNNABLE: rdy_t[s] += dt;
      SS_RUNNING:  run_t[s] += dt;
      SS_SLEEPING: slp_t[s] += dt;
      default: ;
    endcase
    last_t[s] = now_t;
  endfunction

  function automatic logic [31:0] min_live_acc(input int self);
    logic        found;
    logic [31:0] best;
    found = 1'b0;
    best = '0;
    for (int i = 0; i < 64; i++)
      if (i != self && (st[i] == SS_RUNNABLE || st[i] == SS_RUNNING))
        if (!found || acc[i] < best) begin
          best = acc[i];
          found = 1'b1;
        end
    return best;
  endfunction

  function automatic int pick_slot();
    int          best;
    logic [63:0] best_key, key, total;
    best = -1;
    best_key = '0;
    if (pol == POL_ACC || pol == POL_VRT) begin
      for (int i = 0; i < 64; i++) begin
        if (st[i] != SS_RUNNABLE) continue;
        if (pol == POL_ACC) key = {32'd0, acc[i]};
        else begin
          total = 64'(run_t[i]) + 64'(slp_t[i]) + 64'(rdy_t[i]);
          key = (total == 0) ? 64'd0 : (64'(decay[i]) * 64'(run_t[i])) / total;
        end
        if (best < 0 || key < best_key) begin
          best = i;
          best_key = key;
        end
      end
      return best;
    end
    for (int i = 0; i < 64; i++) begin
      int s;
      s = (int'(rr_ptr) + i) % 64;
      if (st[s] == SS_RUNNABLE) begin
        rr_ptr = 6'(s + 1);
        return s;
      end
    end
    return -1;
  endfunction

  function automatic sched_rsp_t predict(input logic [3:0] op, input logic [5:0] s,
                                         input logic [1:0] lvl);
    sched_rsp_t r;
    int         c;
    r = '0;
    case (op)
      OP_TICK: now_t += 1;
      OP_CREATE, OP_SETPRI: begin
        if (lvl == LVL_BAD) r.status = STAT_BAD_PRIO;
        else begin
          decay[s] = 7'(75 + 25 * lvl);
          if (op == OP_CREATE) begin
            st[s] = SS_RUNNABLE;
            run_t[s] = '0;
            slp_t[s] = '0;
            rdy_t[s] = '0;
            last_t[s] = now_t;
            acc[s] = min_live_acc(s);
          end
        end
      end
      OP_YIELD: if (st[s] == SS_RUNNING) begin
        settle(s);
        st[s] = SS_RUNNABLE;
        // saturate rather than wrap
        if (acc[s] > 32'hFFFF_FFFF - acc_step) acc[s] = 32'hFFFF_FFFF;
        else acc[s] += acc_step;
      end
      OP_SLEEP: if (st[s] == SS_RUNNING) begin
        settle(s);
        st[s] = SS_SLEEPING;
      end
      OP_WAKE: if (st[s] == SS_SLEEPING) begin
        settle(s);
        st[s] = SS_RUNNABLE;
        acc[s] = min_live_acc(s);
      end
      OP_PICK: begin
        c = pick_slot();
        if (c < 0) r.status = STAT_NO_RUN;
        else begin
          settle(c);
          st[c] = SS_RUNNING;
          r.chosen = 6'(c);
        end
      end
      OP_FREE: begin
        settle(s);
        st[s] = SS_UNUSED;
      end
      OP_STATS: begin
        if (decay[s] < 75) r.prio = 2'd0;
        else if ((decay[s] - 75) / 25 > 2) r.prio = 2'd2;
        else r.prio = 2'((decay[s] - 75) / 25);
        r.run = run_t[s];
        r.slp = slp_t[s];
        r.rdy = rdy_t[s];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sched_rsp_t w;
    if (rst) begin
      for (int i = 0; i < 64; i++) begin
        st[i] = SS_UNUSED;
        decay[i] = 7'd100;
        acc[i] = '0;
        run_t[i] = '0;
        slp_t[i] = '0;
        rdy_t[i] = '0;
        last_t[i] = '0;
      end
      now_t = '0;
      rr_ptr = '0;
      pol = POL_RR;
      acc_step = 8'd5;
      fail_count = 0;
      expected_rsps.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY) pol = cfg_data[1:0];
        else acc_step = cfg_data;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 32'd1, 32'd0);
        end else begin
          w = expected_rsps.pop_front();
          if (status !== w.status) report("status", status, w.status);
          if (chosen_slot !== w.chosen) report("chosen_slot", chosen_slot, w.chosen);
          if (stat_priority !== w.prio) report("stat_priority", stat_priority, w.prio);
          if (stat_run_time !== w.run) report("stat_run_time", stat_run_time, w.run);
          if (stat_sleep_time !== w.slp) report("stat_sleep_time", stat_sleep_time, w.slp);
          if (stat_ready_time !== w.rdy) report("stat_ready_time", stat_ready_time, w.rdy);
        end
      end
      if (req_valid && req_ready)
        expected_rsps.push_back(predict(opcode, slot, priority_level));
    end
  end

endmodule

FILE: tb/sv/tb_process_table_scheduler.sv
// Top of the process table scheduler testbench: clock, reset, requests,
// configuration phases and verdict. Depends on psch_pkg, process_table_scheduler and psch_checker.
`timescale 1ns / 1ps

module tb_process_table_scheduler;
  import psch_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_POLICY;
  logic [7:0]  cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [3:0]  opcode = OP_TICK;
  logic [5:0]  slot = '0;
  logic [1:0]  priority_level = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  chosen_slot;
  logic [1:0]  stat_priority;
  logic [31:0] stat_run_time, stat_sleep_time, stat_ready_time;
  int          fail_count, pending;
  int          cycle_count = 0;
  logic        hold_off = 1'b0;
  int          burst_left = 0;

  localparam int CYCLE_LIMIT = 3_000_000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  process_table_scheduler dut (.*);

  psch_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL process_table_scheduler");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (hold_off) rsp_ready <= 1'b0;
    else if (cycle_count % 200 < 100) rsp_ready <= 1'b1;
    else rsp_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (5000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // wait for the sender's burst/gap pattern, then offer one request
  task automatic send(input logic [3:0] op, input logic [5:0] s, input logic [1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    opcode <= op;
    slot <= s;
    priority_level <= lvl;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed: create, pick, yield/sleep/wake, setpri, free, stats, ticks
  task automatic random_item();
    logic [3:0] op;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 20) op = OP_TICK;
    else if (r < 30) op = OP_CREATE;
    else if (r < 45) op = OP_PICK;
    else if (r < 55) op = OP_YIELD;
    else if (r < 63) op = OP_SLEEP;
    else if (r < 72) op = OP_WAKE;
    else if (r < 77) op = OP_SETPRI;
    else if (r < 82) op = OP_FREE;
    else if (r < 95) op = OP_STATS;
    else op = 4'($urandom_range(9, 15));
    send(op, ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
         ($urandom_range(0, 9) == 0) ? LVL_BAD : 2'($urandom_range(0, 2)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes of slot and level, each opcode and the odd cases
    send(OP_PICK, 6'd0, 2'd0);
    send(OP_CREATE, 6'd63, 2'd2);
    send(OP_CREATE, 6'd0, 2'd0);
    send(OP_CREATE, 6'd5, LVL_BAD);
    send(OP_SETPRI, 6'd5, LVL_BAD);
    send(OP_YIELD, 6'd0, 2'd0);
    send(OP_WAKE, 6'd0, 2'd0);
    send(OP_PICK, 6'd0, 2'd0);
    send(OP_TICK, 6'd42, 2'd3);
    send(OP_TICK, 6'd21, 2'd0);
    send(OP_YIELD, 6'd0, 2'd0);
    send(OP_PICK, 6'd0, 2'd0);
    send(OP_SLEEP, 6'd63, 2'd0);
    send(OP_TICK, 6'd0, 2'd0);
    send(OP_WAKE, 6'd63, 2'd0);
    send(OP_SETPRI, 6'd63, 2'd0);
    send(OP_STATS, 6'd63, 2'd0);
    send(OP_STATS, 6'd0, 2'd0);
    send(OP_STATS, 6'd30, 2'd0);
    send(OP_FREE, 6'd63, 2'd0);
    send(4'd15, 6'd63, 2'd3);
    send(4'd9, 6'd0, 2'd0);
    send(OP_STATS, 6'd63, 2'd0);
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: ;
        1: write_reg(CFG_POLICY, {6'd0, POL_ACC});
        2: begin write_reg(CFG_POLICY, {6'd0, POL_VRT}); write_reg(CFG_STEP, 8'd255); end
        3: write_reg(CFG_STEP, 8'd1);
        4: write_reg(CFG_POLICY, 8'd3);
        5: begin write_reg(CFG_POLICY, {6'd0, POL_RR}); write_reg(CFG_STEP, 8'd128); end
        default: write_reg(CFG_POLICY, {6'd0, POL_ACC});
      endcase
      for (int n = 0; n < 150; n++) random_item();
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (fail_count == 0) $display("PASS process_table_scheduler");
    else $display("FAIL process_table_scheduler");
    $finish;
  end

endmodule

FILE: files.f
rtl/psch_pkg.sv
rtl/psch_ram.sv
rtl/psch_vrt.sv
rtl/process_table_scheduler.sv
tb/sv/psch_checker.sv
tb/sv/tb_process_table_scheduler.sv
